[sv/bqd_pkg.sv]
package bqd_pkg;

    localparam int COEF_BITS    = 24;
    localparam int OUT_BITS     = 24;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [CFG_IDX_BITS-1:0]     t_cfg_idx;
    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [OUT_BITS-1:0]  t_out;

    // register indexes on the configuration port
    localparam t_cfg_idx REG_B0 = 3'd0;
    localparam t_cfg_idx REG_B1 = 3'd1;
    localparam t_cfg_idx REG_B2 = 3'd2;
    localparam t_cfg_idx REG_A1 = 3'd3;
    localparam t_cfg_idx REG_A2 = 3'd4;

    // 0.5 to 20 Hz band-pass at 500 Hz, Q2.22
    localparam t_coef COEF_B0_RST = 24'sd459856;
    localparam t_coef COEF_B1_RST = 24'sd0;
    localparam t_coef COEF_B2_RST = -24'sd459856;
    localparam t_coef COEF_A1_RST = -24'sd7462970;
    localparam t_coef COEF_A2_RST = 24'sd3274592;

    localparam t_out OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam t_out OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    // command to the shared serial multiplier
    typedef struct packed {
        logic start;
        logic neg;
        logic frac;
    } t_mul_cmd;

    // product being formed for the current channel
    typedef enum logic [2:0] {
        OP_B0 = 3'd0,
        OP_A1 = 3'd1,
        OP_B1 = 3'd2,
        OP_A2 = 3'd3,
        OP_B2 = 3'd4
    } t_op;

endpackage

[sv/bqd_in_if.sv]
interface bqd_in_if #(
    parameter int SAMPLE_BITS = 22
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ir_sample;
    logic signed [SAMPLE_BITS-1:0] red_sample;

    modport source (output valid, output ir_sample, output red_sample, input ready);
    modport sink   (input valid, input ir_sample, input red_sample, output ready);
endinterface

[sv/bqd_out_if.sv]
interface bqd_out_if;
    import bqd_pkg::*;

    logic valid;
    logic ready;
    t_out ir_filtered;
    t_out red_filtered;

    modport source (output valid, output ir_filtered, output red_filtered, input ready);
    modport sink   (input valid, input ir_filtered, input red_filtered, output ready);
endinterface

[sv/bqd_mul.sv]
module bqd_mul #(
    parameter int STATE_BITS     = 48,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bqd_pkg::t_mul_cmd              i_cmd,
    input  logic [STATE_BITS-1:0]          i_mcand,
    input  logic [bqd_pkg::COEF_BITS-1:0]  i_mplier,
    output logic                           o_done,
    output logic signed [STATE_BITS-1:0]   o_res
);
    import bqd_pkg::*;

    localparam int PW       = STATE_BITS + COEF_BITS;
    localparam int CNT_BITS = $clog2(COEF_BITS);
    localparam logic signed [STATE_BITS-1:0] ST_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] ST_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } t_mstate;

    t_mstate                       r_state, n_state;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [PW-1:0]                 r_p;
    logic [STATE_BITS-1:0]         r_mcand;
    logic                          r_neg;
    logic                          r_frac;
    logic                          r_done;
    logic signed [STATE_BITS-1:0]  r_res;

    logic [STATE_BITS:0]           w_sum;
    logic [PW-1:0]                 w_mag;
    logic [COEF_BITS:0]            w_top;
    logic                          w_over;
    logic                          w_exact_min;
    logic signed [STATE_BITS-1:0]  w_res;

    // one multiplier bit per cycle: add the multiplicand into the upper part, shift right
    assign w_sum = {1'b0, r_p[PW-1:COEF_BITS]}
                 + (r_p[0] ? {1'b0, r_mcand} : {(STATE_BITS+1){1'b0}});

    // magnitude shift truncates toward zero
    assign w_mag       = r_frac ? (r_p >> COEF_FRAC_BITS) : r_p;
    assign w_top       = w_mag[PW-1:STATE_BITS-1];
    assign w_over      = |w_top;
    assign w_exact_min = (w_top == {{COEF_BITS{1'b0}}, 1'b1})
                       && (w_mag[STATE_BITS-2:0] == '0);

    always_comb begin
        if (!r_neg) begin
            w_res = w_over ? ST_MAX : w_mag[STATE_BITS-1:0];
        end else begin
            w_res = (w_over && !w_exact_min) ? ST_MIN : -w_mag[STATE_BITS-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE: begin
                if (i_cmd.start) n_state = M_RUN;
            end
            M_RUN: begin
                if (r_cnt == '0) n_state = M_FIN;
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_cmd.start) begin
                    r_p     <= {{STATE_BITS{1'b0}}, i_mplier};
                    r_mcand <= i_mcand;
                    r_neg   <= i_cmd.neg;
                    r_frac  <= i_cmd.frac;
                    r_cnt   <= CNT_BITS'(COEF_BITS - 1);
                end
            end
            M_RUN: begin
                r_p   <= {w_sum, r_p[COEF_BITS-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            M_FIN: begin
                r_res <= w_res;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[sv/bqd_core.sv]
module bqd_core #(
    parameter int SAMPLE_BITS    = 22,
    parameter int COEF_FRAC_BITS = 22,
    parameter int STATE_BITS     = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bqd_pkg::t_coefs               i_coefs,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_ir_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_red_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bqd_pkg::t_out                 o_ir_filtered,
    output bqd_pkg::t_out                 o_red_filtered
);
    import bqd_pkg::*;

    localparam logic signed [STATE_BITS-1:0] ST_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] ST_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic [STATE_BITS-1:0] OUT_POS_LIM = STATE_BITS'(2**(OUT_BITS-1) - 1);
    localparam logic [STATE_BITS-1:0] OUT_NEG_LIM = STATE_BITS'(2**(OUT_BITS-1));

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_WAIT  = 5'b00100,
        S_ADD   = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    t_state                          r_state;
    t_op                             r_op;
    logic                            r_ch;
    logic signed [SAMPLE_BITS-1:0]   r_ir_x;
    logic signed [SAMPLE_BITS-1:0]   r_red_x;
    logic signed [STATE_BITS-1:0]    r_d1 [2];
    logic signed [STATE_BITS-1:0]    r_d2 [2];
    logic signed [STATE_BITS-1:0]    r_y;
    logic signed [STATE_BITS-1:0]    r_t;
    t_out                            r_res_ir;
    t_out                            r_res_red;
    logic                            r_ovalid;
    t_out                            r_ir_out;
    t_out                            r_red_out;

    logic signed [SAMPLE_BITS-1:0]   w_x;
    logic signed [STATE_BITS-1:0]    w_xs;
    logic [STATE_BITS-1:0]           w_x_mag;
    logic [STATE_BITS-1:0]           w_y_mag;
    logic [STATE_BITS-1:0]           w_q;
    t_coef                           w_coef;
    logic [COEF_BITS-1:0]            w_c_mag;
    logic                            w_use_y;
    t_mul_cmd                        w_cmd;
    logic [STATE_BITS-1:0]           w_mcand;
    logic                            w_mul_done;
    logic signed [STATE_BITS-1:0]    w_mul_res;
    t_out                            w_out;
    logic                            w_out_free;
    logic                            w_load;

    function automatic logic signed [STATE_BITS-1:0] f_sat_addsub(
        input logic signed [STATE_BITS-1:0] a,
        input logic signed [STATE_BITS-1:0] b,
        input logic                         sub
    );
        logic [STATE_BITS:0] s;
        if (sub) begin
            s = {a[STATE_BITS-1], a} - {b[STATE_BITS-1], b};
        end else begin
            s = {a[STATE_BITS-1], a} + {b[STATE_BITS-1], b};
        end
        if (s[STATE_BITS] != s[STATE_BITS-1]) begin
            f_sat_addsub = s[STATE_BITS] ? ST_MIN : ST_MAX;
        end else begin
            f_sat_addsub = s[STATE_BITS-1:0];
        end
    endfunction

    assign w_x     = r_ch ? r_red_x : r_ir_x;
    assign w_xs    = STATE_BITS'(w_x);
    assign w_x_mag = w_xs[STATE_BITS-1] ? STATE_BITS'(-w_xs) : STATE_BITS'(w_xs);
    assign w_y_mag = r_y[STATE_BITS-1] ? STATE_BITS'(-r_y) : STATE_BITS'(r_y);

    always_comb begin
        case (r_op)
            OP_B0:   w_coef = i_coefs.b0;
            OP_A1:   w_coef = i_coefs.a1;
            OP_B1:   w_coef = i_coefs.b1;
            OP_A2:   w_coef = i_coefs.a2;
            OP_B2:   w_coef = i_coefs.b2;
            default: w_coef = i_coefs.b0;
        endcase
    end

    assign w_c_mag = w_coef[COEF_BITS-1] ? COEF_BITS'(-w_coef) : COEF_BITS'(w_coef);

    // feedback products take y and drop the coefficient fraction
    assign w_use_y   = (r_op == OP_A1) || (r_op == OP_A2);
    assign w_mcand   = w_use_y ? w_y_mag : w_x_mag;
    assign w_cmd.start = (r_state == S_START);
    assign w_cmd.frac  = w_use_y;
    assign w_cmd.neg   = (w_use_y ? r_y[STATE_BITS-1] : w_xs[STATE_BITS-1])
                       ^ w_coef[COEF_BITS-1];

    bqd_mul #(
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mcand  (w_mcand),
        .i_mplier (w_c_mag),
        .o_done   (w_mul_done),
        .o_res    (w_mul_res)
    );

    // y to integer output: truncate toward zero, saturate
    assign w_q = w_y_mag >> COEF_FRAC_BITS;

    always_comb begin
        if (r_y[STATE_BITS-1]) begin
            w_out = (w_q > OUT_NEG_LIM) ? OUT_MIN : -w_q[OUT_BITS-1:0];
        end else begin
            w_out = (w_q > OUT_POS_LIM) ? OUT_MAX : w_q[OUT_BITS-1:0];
        end
    end

    assign w_out_free = !r_ovalid || i_out_ready;

    // both channels done and the output register can take the pair
    assign w_load = w_out_free
                  && (((r_state == S_WAIT) && w_mul_done && (r_op == OP_B2) && r_ch)
                      || (r_state == S_HOLD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ir_out  <= r_res_ir;
            r_red_out <= r_res_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_B0;
            r_ch     <= 1'b0;
            r_d1[0]  <= '0;
            r_d1[1]  <= '0;
            r_d2[0]  <= '0;
            r_d2[1]  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ir_x  <= i_ir_sample;
                        r_red_x <= i_red_sample;
                        r_ch    <= 1'b0;
                        r_op    <= OP_B0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mul_done) begin
                        case (r_op)
                            OP_B0: begin
                                r_y     <= f_sat_addsub(w_mul_res, r_d1[r_ch], 1'b0);
                                r_op    <= OP_A1;
                                r_state <= S_START;
                            end
                            OP_A1: begin
                                r_t     <= w_mul_res;
                                r_op    <= OP_B1;
                                r_state <= S_START;
                            end
                            OP_B1: begin
                                r_t     <= f_sat_addsub(w_mul_res, r_t, 1'b1);
                                r_state <= S_ADD;
                            end
                            OP_A2: begin
                                r_t     <= w_mul_res;
                                r_op    <= OP_B2;
                                r_state <= S_START;
                            end
                            OP_B2: begin
                                r_d2[r_ch] <= f_sat_addsub(w_mul_res, r_t, 1'b1);
                                if (!r_ch) begin
                                    r_ch    <= 1'b1;
                                    r_op    <= OP_B0;
                                    r_state <= S_START;
                                end else if (w_out_free) begin
                                    r_state <= S_IDLE;
                                end else begin
                                    r_state <= S_HOLD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    // d2 still holds its old value here
                    r_d1[r_ch] <= f_sat_addsub(r_t, r_d2[r_ch], 1'b0);
                    if (r_ch) r_res_red <= w_out;
                    else      r_res_ir  <= w_out;
                    r_op    <= OP_A2;
                    r_state <= S_START;
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_ir_filtered  = r_ir_out;
    assign o_red_filtered = r_red_out;

endmodule

[sv/dual_channel_bandpass_biquad.sv]
// port       dir  handshake        payload
// i_sample   in   valid / ready    ir_sample, red_sample (SAMPLE_BITS, signed)
// o_result   out  valid / ready    ir_filtered, red_filtered (24 bits, signed)
// i_cfg_*    in   i_cfg_we         i_cfg_idx, i_cfg_data (24 bits, signed Q2.22)
//
// each transaction runs ten products through the one shared multiplier, which takes one
// coefficient bit per cycle, plus a state update step per channel and the accept step
// reset (synchronous, active low) restores the coefficients and clears the filter state
// the result sits in an output register while the next transaction is accepted; the
// core stalls only if that result is still not taken when the next one is done
module dual_channel_bandpass_biquad #(
    parameter int SAMPLE_BITS    = 22,
    parameter int COEF_FRAC_BITS = 22,
    parameter int STATE_BITS     = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bqd_in_if.sink                i_sample,
    bqd_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  bqd_pkg::t_cfg_idx     i_cfg_idx,
    input  bqd_pkg::t_coef        i_cfg_data
);
    import bqd_pkg::*;

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_B0_RST;
            r_coefs.b1 <= COEF_B1_RST;
            r_coefs.b2 <= COEF_B2_RST;
            r_coefs.a1 <= COEF_A1_RST;
            r_coefs.a2 <= COEF_A2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_coefs.b0 <= i_cfg_data;
                REG_B1:  r_coefs.b1 <= i_cfg_data;
                REG_B2:  r_coefs.b2 <= i_cfg_data;
                REG_A1:  r_coefs.a1 <= i_cfg_data;
                REG_A2:  r_coefs.a2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bqd_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_coefs        (r_coefs),
        .i_in_valid     (i_sample.valid),
        .o_in_ready     (i_sample.ready),
        .i_ir_sample    (i_sample.ir_sample),
        .i_red_sample   (i_sample.red_sample),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .o_ir_filtered  (o_result.ir_filtered),
        .o_red_filtered (o_result.red_filtered)
    );

endmodule

[sv/bqd_chk.sv]
module bqd_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic [1:0] r_pend;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd2) |-> !i_in_ready)
        else $error("input ready with two transactions in flight");

    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != 2'd0))
        else $error("result shown with nothing accepted");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend == 2'd0) && w_in_acc) |=> !i_out_valid)
        else $error("result appeared one cycle after an idle accept");

endmodule

bind dual_channel_bandpass_biquad bqd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);

[dv/dual_channel_bandpass_biquad_tb.sv]
module dual_channel_bandpass_biquad_tb;
    import bqd_pkg::*;

    localparam int SAMPLE_BITS    = 22;
    localparam int COEF_FRAC_BITS = 22;
    localparam int STATE_BITS     = 48;
    localparam int NUM_COEF       = REG_A2 + 1;
    localparam int STUCK_LIMIT    = 10000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 2500;
    localparam int PHASE_ITEMS    = 355;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [127:0]           t_wide;

    typedef struct packed {
        t_sample ir;
        t_sample red;
    } t_pair;

    typedef struct packed {
        t_out ir;
        t_out red;
    } t_filtered;

    localparam t_sample SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_coef   COEF_HI   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam t_coef   COEF_LO   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam t_wide   STATE_HI  = (t_wide'(1) <<< (STATE_BITS - 1)) - 1;
    localparam t_wide   STATE_LO  = -(STATE_HI + 1);

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_coef    i_cfg_data;

    bqd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
    bqd_out_if                             result_if ();

    dual_channel_bandpass_biquad #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .STATE_BITS    (STATE_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (sample_if),
        .o_result  (result_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // filter model: shared coefficients and per-channel delay state
    t_coef   coef_now [NUM_COEF];
    longint  ir_d1, ir_d2, red_d1, red_d2;

    t_pair     samples_to_send [$];
    t_filtered filtered_due [$];

    int  err_count;
    int  accept_count;
    int  stuck_cycles;
    int  in_gap;
    int  out_gap;
    int  hold_ask;
    int  hold_left;
    bit  in_hit;
    bit  idling_on;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint sat_state(input t_wide v);
        if (v > STATE_HI) return longint'(STATE_HI);
        if (v < STATE_LO) return longint'(STATE_LO);
        return longint'(v);
    endfunction

    // y * c with the fraction dropped toward zero
    function automatic longint frac_product(input longint y, input t_coef c);
        t_wide yw, cw, p, m;
        yw = y;
        cw = c;
        p  = yw * cw;
        m  = (p < 0) ? -p : p;
        m  = m >>> COEF_FRAC_BITS;
        if (p < 0) m = -m;
        return sat_state(m);
    endfunction

    task automatic bandpass_section(input longint x, inout longint d1, inout longint d2,
                                    output t_out y_out);
        t_wide  xw, q;
        longint y, n1, n2;
        xw = x;
        y  = sat_state(t_wide'(sat_state(xw * t_wide'(coef_now[REG_B0]))) + t_wide'(d1));
        n1 = sat_state(t_wide'(sat_state(xw * t_wide'(coef_now[REG_B1])))
                       - t_wide'(frac_product(y, coef_now[REG_A1])));
        n1 = sat_state(t_wide'(n1) + t_wide'(d2));
        n2 = sat_state(t_wide'(sat_state(xw * t_wide'(coef_now[REG_B2])))
                       - t_wide'(frac_product(y, coef_now[REG_A2])));
        d1 = n1;
        d2 = n2;
        q = (y < 0) ? -t_wide'(y) : t_wide'(y);
        q = q >>> COEF_FRAC_BITS;
        if (y < 0) q = -q;
        if (q > t_wide'(OUT_MAX)) y_out = OUT_MAX;
        else if (q < t_wide'(OUT_MIN)) y_out = OUT_MIN;
        else y_out = t_out'(q);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // input side: prediction on every accepted transaction
    always @(posedge i_clk) begin
        t_filtered due;
        if (i_rst_n && sample_if.valid && sample_if.ready) begin
            bandpass_section(sample_if.ir_sample, ir_d1, ir_d2, due.ir);
            bandpass_section(sample_if.red_sample, red_d1, red_d2, due.red);
            filtered_due.push_back(due);
            accept_count++;
            in_hit = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        logic  next_valid;
        t_pair item;
        next_valid = sample_if.valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!sample_if.valid || in_hit) begin
            in_hit     = 1'b0;
            next_valid = 1'b0;
            if (in_gap != 0) begin
                in_gap--;
            end else if (samples_to_send.size() != 0) begin
                if (idling_on && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 11);
                end else begin
                    item = samples_to_send.pop_front();
                    sample_if.ir_sample  <= item.ir;
                    sample_if.red_sample <= item.red;
                    next_valid = 1'b1;
                end
            end
        end
        sample_if.valid <= next_valid;
    end

    // output side
    always @(posedge i_clk) begin
        t_filtered due;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (filtered_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing due: ir %0d red %0d",
                                          result_if.ir_filtered, result_if.red_filtered));
            end else begin
                due = filtered_due.pop_front();
                if (result_if.ir_filtered !== due.ir)
                    report_mismatch($sformatf("ir_filtered %0d, want %0d",
                                              result_if.ir_filtered, due.ir));
                if (result_if.red_filtered !== due.red)
                    report_mismatch($sformatf("red_filtered %0d, want %0d",
                                              result_if.red_filtered, due.red));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap--;
            result_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 15) == 0) begin
            out_gap = $urandom_range(0, 11);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // ends the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_coef(input t_cfg_idx idx, input t_coef val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        if (idx <= REG_A2) coef_now[idx] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_coef_set(input t_coef b0, input t_coef b1, input t_coef b2,
                                  input t_coef a1, input t_coef a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || sample_if.valid || filtered_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_pair(input t_sample ir, input t_sample red);
        t_pair p;
        p.ir  = ir;
        p.red = red;
        samples_to_send.push_back(p);
    endtask

    function automatic t_sample pick_extreme();
        case ($urandom_range(0, 4))
            0: return SAMPLE_HI;
            1: return SAMPLE_LO;
            2: return '0;
            3: return '1;
            default: return t_sample'(1);
        endcase
    endfunction

    function automatic t_coef pick_coef_extreme();
        case ($urandom_range(0, 4))
            0: return COEF_HI;
            1: return COEF_LO;
            2: return '0;
            3: return '1;
            default: return t_coef'(1);
        endcase
    endfunction

    // segments of signal-like content: steps, random walks, noise and extremes
    task automatic queue_signal(input int n);
        int      seg, kind;
        t_sample w_ir, w_red;
        while (n > 0) begin
            seg = $urandom_range(4, 40);
            if (seg > n) seg = n;
            kind  = $urandom_range(0, 3);
            w_ir  = t_sample'($urandom);
            w_red = t_sample'($urandom);
            for (int k = 0; k < seg; k++) begin
                case (kind)
                    0: send_pair(w_ir + t_sample'($signed(4'($urandom))),
                                 w_red + t_sample'($signed(4'($urandom))));
                    1: begin
                        w_ir  = w_ir + t_sample'($signed(14'($urandom)));
                        w_red = w_red + t_sample'($signed(14'($urandom)));
                        send_pair(w_ir, w_red);
                    end
                    2: send_pair(t_sample'($urandom), t_sample'($urandom));
                    default: send_pair(pick_extreme(), pick_extreme());
                endcase
            end
            n -= seg;
        end
    endtask

    initial begin
        int mark;
        sample_if.valid      = 1'b0;
        sample_if.ir_sample  = '0;
        sample_if.red_sample = '0;
        result_if.ready      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_B0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        err_count    = 0;
        accept_count = 0;
        stuck_cycles = 0;
        in_gap    = 0;
        out_gap   = 0;
        hold_ask  = 0;
        hold_left = 0;
        in_hit    = 1'b0;
        idling_on = 1'b1;
        coef_now[REG_B0] = COEF_B0_RST;
        coef_now[REG_B1] = COEF_B1_RST;
        coef_now[REG_B2] = COEF_B2_RST;
        coef_now[REG_A1] = COEF_A1_RST;
        coef_now[REG_A2] = COEF_A2_RST;
        ir_d1  = 0;
        ir_d2  = 0;
        red_d1 = 0;
        red_d2 = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients, full-scale steps and small values
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_LO, SAMPLE_HI);
        send_pair('0, '0);
        send_pair('1, t_sample'(1));
        send_pair(t_sample'(1), '1);
        send_pair('0, '0);
        wait_drained();

        // largest coefficients drive state and output into saturation
        write_coef_set(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI);
        // writes to unused indexes must change nothing
        for (int k = NUM_COEF; k < 2 ** CFG_IDX_BITS; k++)
            write_coef(t_cfg_idx'(k), t_coef'($urandom));
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_HI, SAMPLE_LO);
        send_pair(SAMPLE_LO, SAMPLE_HI);
        send_pair('0, '0);
        wait_drained();

        write_coef_set(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO);
        send_pair(SAMPLE_LO, SAMPLE_HI);
        send_pair(SAMPLE_LO, SAMPLE_HI);
        send_pair(SAMPLE_HI, '0);
        send_pair(SAMPLE_HI, '1);
        send_pair('0, SAMPLE_LO);
        wait_drained();

        write_coef_set(COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST);
        send_pair(SAMPLE_HI, SAMPLE_HI);
        send_pair(SAMPLE_LO, SAMPLE_LO);
        send_pair('0, '0);
        send_pair('1, '1);
        wait_drained();

        // random part: the band-pass as used
        queue_signal(PHASE_ITEMS);
        wait_drained();

        write_coef_set(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                       t_coef'($urandom), t_coef'($urandom));
        queue_signal(PHASE_ITEMS);
        wait_drained();

        // modest coefficients; receiver holds off to back the block up
        write_coef_set(t_coef'($signed(22'($urandom))), t_coef'($signed(22'($urandom))),
                       t_coef'($signed(22'($urandom))), t_coef'($signed(22'($urandom))),
                       t_coef'($signed(21'($urandom))));
        queue_signal(PHASE_ITEMS);
        mark = accept_count;
        wait (accept_count >= mark + 30);
        hold_ask = HOLD_CYCLES;
        wait_drained();

        write_coef_set(pick_coef_extreme(), pick_coef_extreme(), pick_coef_extreme(),
                       pick_coef_extreme(), pick_coef_extreme());
        queue_signal(PHASE_ITEMS);
        wait_drained();

        // last stretch at full rate
        write_coef_set(COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST);
        idling_on = 1'b0;
        queue_signal(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
sv/bqd_pkg.sv
sv/bqd_in_if.sv
sv/bqd_out_if.sv
sv/bqd_mul.sv
sv/bqd_core.sv
sv/dual_channel_bandpass_biquad.sv
sv/bqd_chk.sv
dv/dual_channel_bandpass_biquad_tb.sv
